// ----- rtl/lgb_pkg.sv -----
`timescale 1ns / 1ps

package lgb_pkg;

  localparam int LINE_CAPACITY_DEF = 128;
  localparam int QUEUE_DEPTH       = 2;

  // request codes as they arrive on the input channel
  localparam logic [2:0] REQ_INSERT   = 3'd0;
  localparam logic [2:0] REQ_DEL_BACK = 3'd1;
  localparam logic [2:0] REQ_DEL_FWD  = 3'd2;
  localparam logic [2:0] REQ_MOVE     = 3'd3;
  localparam logic [2:0] REQ_READ     = 3'd4;
  localparam logic [2:0] REQ_CLEAR    = 3'd5;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_IGNORED  = 2'd1;
  localparam logic [1:0] ST_CLAMPED  = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DEL_BACK,
    OP_DEL_FWD,
    OP_MOVE,
    OP_READ,
    OP_CLEAR,
    OP_BAD
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_MOVE,
    S_EMIT
  } back_state_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_in;
    logic [7:0] move_count;
    logic       move_forward;
    logic [6:0] read_position;
  } req_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [1:0] status;
    logic [7:0] text_len;
    logic [7:0] cursor;
  } res_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_in;
    logic [7:0] move_count;
    logic       move_forward;
    logic [6:0] read_position;
  } cmd_t;

endpackage

// ----- rtl/line_gap_buffer.sv -----
`timescale 1ns / 1ps
// line_gap_buffer: one text line kept as a gap buffer around the cursor.
// Input channel in_valid_i / in_ready_o / in_i carries one request per beat:
// insert, delete back, delete forward, move gap, read or clear. Every request
// gives exactly one result beat on out_valid_o / out_ready_i / out_o with the
// read character, a status code, the line length and the cursor afterwards.
// Requests enter a two-entry queue, so up to two can be taken while the
// engine is busy. The engine handles one request at a time on a single
// character memory (one write and one registered read port):
//   insert, delete, clear, rejected requests: straight from idle to emit
//   read: one memory read, then a read-wait state, then emit
//   move by n characters: a move state, one character copied per cycle, then emit
// A finished result sits in an output register; if the receiver stalls, the
// engine holds its next result until the register empties, and the queue
// keeps taking requests until full.
// Reset empties the line (cursor 0, length 0) and drops queued requests;
// the character memory is not cleared and needs no clearing pass.
module line_gap_buffer
  import lgb_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  lgb_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_o       (push_cmd)
  );

  lgb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_o        (pop_cmd)
  );

  lgb_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/lgb_ram.sv -----
`timescale 1ns / 1ps

module lgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/lgb_front.sv -----
`timescale 1ns / 1ps

module lgb_front
  import lgb_pkg::*;
(
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_i,
  output logic push_valid_o,
  input  logic push_ready_i,
  output cmd_t push_o
);

  op_e op;

  always_comb begin
    case (in_i.req_type)
      REQ_INSERT:   op = OP_INSERT;
      REQ_DEL_BACK: op = OP_DEL_BACK;
      REQ_DEL_FWD:  op = OP_DEL_FWD;
      REQ_MOVE:     op = OP_MOVE;
      REQ_READ:     op = OP_READ;
      REQ_CLEAR:    op = OP_CLEAR;
      default:      op = OP_BAD;
    endcase
  end

  assign push_o.op            = op;
  assign push_o.char_in       = in_i.char_in;
  assign push_o.move_count    = in_i.move_count;
  assign push_o.move_forward  = in_i.move_forward;
  assign push_o.read_position = in_i.read_position;

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

// ----- rtl/lgb_queue.sv -----
`timescale 1ns / 1ps

module lgb_queue
  import lgb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t            buf_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = buf_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

// ----- rtl/lgb_back.sv -----
`timescale 1ns / 1ps

module lgb_back
  import lgb_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  localparam int         AW  = $clog2(LINE_CAPACITY);
  localparam logic [7:0] CAP = 8'(LINE_CAPACITY);

  back_state_e state_q, state_d;

  logic [7:0] gf_q, gf_d;
  logic [7:0] gp_q, gp_d;
  logic [7:0] src_q, src_d;
  logic [7:0] dst_q, dst_d;
  logic [7:0] left_q, left_d;
  logic [7:0] n_q, n_d;
  logic       fwd_q, fwd_d;
  logic       pend_q, pend_d;
  logic [7:0] rd_char_q, rd_char_d;
  logic [1:0] status_q, status_d;
  logic       out_valid_q, out_valid_d;
  res_t       out_q, out_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  logic [7:0] len, avail, n_mv, idx;
  logic       slot_free;

  lgb_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign len       = CAP - (gp_q - gf_q);
  assign avail     = cmd_i.move_forward ? (CAP - gp_q) : gf_q;
  assign n_mv      = (cmd_i.move_count > avail) ? avail : cmd_i.move_count;
  assign idx       = ({1'b0, cmd_i.read_position} < gf_q) ? {1'b0, cmd_i.read_position}
                   : {1'b0, cmd_i.read_position} + (gp_q - gf_q);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    gf_d        = gf_q;
    gp_d        = gp_q;
    src_d       = src_q;
    dst_d       = dst_q;
    left_d      = left_q;
    n_d         = n_q;
    fwd_d       = fwd_q;
    pend_d      = 1'b0;
    rd_char_d   = rd_char_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd_ready_o = 1'b0;
    we          = 1'b0;
    waddr       = gf_q[AW-1:0];
    wdata       = cmd_i.char_in;
    re          = 1'b0;
    raddr       = idx[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          rd_char_d   = '0;
          status_d    = ST_DONE;
          state_d     = S_EMIT;
          case (cmd_i.op)
            OP_INSERT: begin
              if (gf_q < gp_q) begin
                we   = 1'b1;
                gf_d = gf_q + 1'b1;
              end else begin
                status_d = ST_IGNORED;
              end
            end
            OP_DEL_BACK: begin
              if (gf_q != '0) gf_d = gf_q - 1'b1;
              else status_d = ST_IGNORED;
            end
            OP_DEL_FWD: begin
              if (gp_q < CAP) gp_d = gp_q + 1'b1;
              else status_d = ST_IGNORED;
            end
            OP_MOVE: begin
              if (cmd_i.move_count > avail) status_d = ST_CLAMPED;
              n_d    = n_mv;
              left_d = n_mv;
              fwd_d  = cmd_i.move_forward;
              src_d  = cmd_i.move_forward ? gp_q : gf_q - 1'b1;
              dst_d  = cmd_i.move_forward ? gf_q : gp_q - 1'b1;
              if (n_mv != '0) state_d = S_MOVE;
            end
            OP_READ: begin
              if ({1'b0, cmd_i.read_position} >= len) begin
                status_d = ST_PAST_END;
              end else begin
                re      = 1'b1;
                state_d = S_RDWAIT;
              end
            end
            OP_CLEAR: begin
              gf_d = '0;
              gp_d = CAP;
            end
            default: status_d = ST_IGNORED;
          endcase
        end
      end
      S_RDWAIT: begin
        rd_char_d = rdata;
        state_d   = S_EMIT;
      end
      S_MOVE: begin
        // read one character ahead, write the one fetched last cycle
        raddr = src_q[AW-1:0];
        waddr = dst_q[AW-1:0];
        wdata = rdata;
        if (left_q != '0) begin
          re     = 1'b1;
          pend_d = 1'b1;
          left_d = left_q - 1'b1;
          src_d  = fwd_q ? src_q + 1'b1 : src_q - 1'b1;
        end
        if (pend_q) begin
          we    = 1'b1;
          dst_d = fwd_q ? dst_q + 1'b1 : dst_q - 1'b1;
        end
        if (left_q == '0 && !pend_q) begin
          gf_d    = fwd_q ? gf_q + n_q : gf_q - n_q;
          gp_d    = fwd_q ? gp_q + n_q : gp_q - n_q;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.read_char   = rd_char_q;
          out_d.status      = status_q;
          out_d.text_len    = len;
          out_d.cursor      = gf_q;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gf_q        <= '0;
      gp_q        <= CAP;
      left_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      gf_q        <= gf_d;
      gp_q        <= gp_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q     <= src_d;
    dst_q     <= dst_d;
    n_q       <= n_d;
    fwd_q     <= fwd_d;
    rd_char_q <= rd_char_d;
    status_q  <= status_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/lgb_checker.sv -----
`timescale 1ns / 1ps

module lgb_checker
  import lgb_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input res_t out_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.cursor <= out_o.text_len
                 && out_o.text_len <= 8'(LINE_CAPACITY))
    else $error("cursor or length out of range");

  // only a successful read carries a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ST_DONE |-> out_o.read_char == '0)
    else $error("character on a failed request");

  // a stalled request beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_i))
    else $error("request beat changed while stalled");

endmodule

bind line_gap_buffer lgb_checker #(
  .LINE_CAPACITY (LINE_CAPACITY)
) u_lgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
